@@ sv/updec_pkg.sv @@
// shared types, codes and helpers for the url percent decoder
package updec_pkg;

    localparam logic [7:0] CHAR_PERCENT  = 8'h25;
    localparam logic [7:0] CHAR_QUESTION = 8'h3F;

    localparam int MAX_RESULTS = 3;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'b0001,
        MODE_PCT     = 4'b0010,
        MODE_PCT_HEX = 4'b0100,
        MODE_REST    = 4'b1000
    } mode_t;

    typedef enum logic [1:0] {
        PART_PATH   = 2'd0,
        PART_MARK   = 2'd1,
        PART_REMAIN = 2'd2
    } part_t;

    typedef struct packed {
        logic [7:0] out_byte;
        part_t      part;
        logic       end_of_run;
    } result_t;

    localparam logic CFG_IDX_CUT = 1'b0;

    function automatic logic is_hex(input logic [7:0] c);
        logic r;
        r = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
        return r;
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            v = c[3:0];
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

@@ sv/url_percent_decoder_top.sv @@
// url percent decoder: streaming %XX unescape with optional cut at the query
// One input byte is accepted per cycle while s_tready is high. A byte is
// decoded into a three-entry result register, which is drained one result
// per cycle on the master side while m_tready is high. A byte that yields
// more than one result (at most three: a broken escape flush plus the byte
// itself, or an end-of-string flush) keeps s_tready low while the register
// drains, until one result is left and m_tready is high. cut_at_query is
// written over the APB port at byte address 0 and sampled on every byte.
module url_percent_decoder_top
    import updec_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [1:0]  m_tuser,   // [1:0] part
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       cut_reg;
    mode_t      mode_reg, mode_next;
    logic [7:0] held_reg, held_next;
    result_t    buf_reg [MAX_RESULTS];
    result_t    buf_next [MAX_RESULTS];
    logic [1:0] cnt_reg, cnt_next;

    result_t    res [MAX_RESULTS];
    logic [2:0] n;
    logic       s_acc, m_take;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_IDX_CUT) ? {31'd0, cut_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cut_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == CFG_IDX_CUT) begin
            cut_reg <= pwdata[0];
        end
    end

    // handshakes
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_take   = m_tvalid && m_tready;
    assign s_tready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);
    assign s_acc    = s_tvalid && s_tready;

    assign m_tdata = buf_reg[0].out_byte;
    assign m_tuser = buf_reg[0].part;
    assign m_tlast = buf_reg[0].end_of_run;

    // decode of one byte
    always_comb begin
        logic [7:0] b;
        logic       take_idle;
        b         = s_tdata;
        take_idle = 1'b0;
        n         = 3'd0;
        mode_next = mode_reg;
        held_next = held_reg;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            res[i] = '{out_byte: 8'd0, part: PART_PATH, end_of_run: 1'b0};
        end

        case (mode_reg)
            MODE_REST: begin
                res[0] = '{out_byte: b, part: PART_REMAIN, end_of_run: 1'b0};
                n = 3'd1;
            end
            MODE_PCT: begin
                if (is_hex(b)) begin
                    held_next = b;
                    mode_next = MODE_PCT_HEX;
                end else begin
                    res[0] = '{out_byte: CHAR_PERCENT, part: PART_PATH, end_of_run: 1'b0};
                    n = 3'd1;
                    take_idle = 1'b1;
                end
            end
            MODE_PCT_HEX: begin
                if (is_hex(b)) begin
                    res[0] = '{out_byte: {hex_val(held_reg), hex_val(b)}, part: PART_PATH,
                               end_of_run: 1'b0};
                    n = 3'd1;
                    held_next = 8'd0;
                    mode_next = MODE_IDLE;
                end else begin
                    res[0] = '{out_byte: CHAR_PERCENT, part: PART_PATH, end_of_run: 1'b0};
                    res[1] = '{out_byte: held_reg, part: PART_PATH, end_of_run: 1'b0};
                    n = 3'd2;
                    held_next = 8'd0;
                    take_idle = 1'b1;
                end
            end
            default: begin
                take_idle = 1'b1;
            end
        endcase

        if (take_idle) begin
            if (b == CHAR_PERCENT) begin
                mode_next = MODE_PCT;
            end else if (cut_reg && b == CHAR_QUESTION) begin
                res[n[1:0]] = '{out_byte: 8'd0, part: PART_MARK, end_of_run: 1'b0};
                n = n + 3'd1;
                mode_next = MODE_REST;
            end else begin
                res[n[1:0]] = '{out_byte: b, part: PART_PATH, end_of_run: 1'b0};
                n = n + 3'd1;
                mode_next = MODE_IDLE;
            end
        end

        if (s_tlast) begin
            // end of string: flush a pending escape
            if (mode_next == MODE_PCT || mode_next == MODE_PCT_HEX) begin
                if (n < 3'd3) begin
                    res[n[1:0]] = '{out_byte: CHAR_PERCENT, part: PART_PATH, end_of_run: 1'b0};
                    n = n + 3'd1;
                end
            end
            if (mode_next == MODE_PCT_HEX) begin
                if (n < 3'd3) begin
                    res[n[1:0]] = '{out_byte: held_next, part: PART_PATH, end_of_run: 1'b0};
                    n = n + 3'd1;
                end
            end
            mode_next = MODE_IDLE;
            held_next = 8'd0;
            if (n != 3'd0) begin
                res[2'(n - 3'd1)].end_of_run = 1'b1;
            end
        end
    end

    // result register
    always_comb begin
        cnt_next = cnt_reg;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            buf_next[i] = buf_reg[i];
        end
        if (s_acc) begin
            cnt_next = n[1:0];
            for (int i = 0; i < MAX_RESULTS; i++) begin
                buf_next[i] = res[i];
            end
        end else if (m_take) begin
            cnt_next = cnt_reg - 2'd1;
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                buf_next[i] = buf_reg[i + 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            held_reg <= 8'd0;
            cnt_reg  <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (s_acc) begin
                mode_reg <= mode_next;
                held_reg <= held_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            buf_reg[i] <= buf_next[i];
        end
    end

`ifndef SYNTHESIS
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tlast |=> m_tvalid)
        else $error("no result after end of string");

    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tlast |=> mode_reg == MODE_IDLE)
        else $error("decoder not idle after end of string");

    a_held_only_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg != MODE_PCT_HEX |-> held_reg == 8'd0)
        else $error("held digit outside pending escape");

    a_mark_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == PART_MARK |-> m_tdata == 8'd0)
        else $error("cut marker carries data");

    a_mode_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(mode_reg))
        else $error("decode mode not one-hot");
`endif

endmodule
